>>> rtl/crcdfr_pkg.sv
// shared types, constants and the crc32 byte update for the packet deframer
// no dependencies
package crcdfr_pkg;

  // status codes of the final item
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_NO_HEADER    = 3'd1;
  localparam logic [2:0] ST_BAD_TYPE     = 3'd2;
  localparam logic [2:0] ST_BAD_WINDOW   = 3'd3;
  localparam logic [2:0] ST_BAD_LENGTH   = 3'd4;
  localparam logic [2:0] ST_CRC_ERROR    = 3'd5;
  localparam logic [2:0] ST_INCONSISTENT = 3'd6;

  // result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // configuration register indexes
  localparam logic REG_MAX_WINDOW = 1'b0;
  localparam logic REG_TYPE_MASK  = 1'b1;

  // defaults
  localparam int unsigned MAX_PAYLOAD_DEFAULT = 512;
  localparam logic [4:0]  MAX_WINDOW_RESET    = 5'd31;
  localparam logic [3:0]  TYPE_MASK_RESET     = 4'd14;

  // crc32 (reflected, zlib form)
  localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
  localparam logic [31:0] CRC_PRESET = 32'hFFFFFFFF;

  // header layout and counter limits
  localparam int unsigned POS_W      = 17;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
  localparam int unsigned HDR_BYTES  = 12;

  // result queue
  localparam int unsigned QUEUE_DEPTH = 8;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [2:0]  status;
    logic [1:0]  pkt_type;
    logic        truncated;
    logic [4:0]  window;
    logic [7:0]  seqnum;
    logic [15:0] payload_length;
    logic [31:0] timestamp;
    logic [31:0] header_crc;
    logic [31:0] payload_crc;
  } result_t;

  typedef struct packed {
    logic [4:0] max_window;
    logic [3:0] type_mask;
  } cfg_t;

  // one byte through the crc32 shift register, bit at a time
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'b0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> rtl/crcdfr_cfg_regs.sv
// apb configuration registers: max window and accepted type mask
// depends on crcdfr_pkg
module crcdfr_cfg_regs
  import crcdfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic [4:0] max_window;
  logic [3:0] type_mask;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register writes, word aligned, low address bits ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      max_window <= MAX_WINDOW_RESET;
      type_mask  <= TYPE_MASK_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_MAX_WINDOW: max_window <= pwdata[4:0];
        REG_TYPE_MASK:  type_mask  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (paddr[2])
      REG_MAX_WINDOW: prdata = {27'b0, max_window};
      REG_TYPE_MASK:  prdata = {28'b0, type_mask};
      default:        prdata = 32'b0;
    endcase
  end

  assign cfg.max_window = max_window;
  assign cfg.type_mask  = type_mask;

endmodule

>>> rtl/crcdfr_parse.sv
// byte stage and header/payload parser; produces up to two results per byte
// depends on crcdfr_pkg
module crcdfr_parse
  import crcdfr_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
)
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       in_take,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       stage_busy,
  output logic [1:0] wr_count,
  output result_t    wr0,
  output result_t    wr1
);

  // input stage
  logic       s_valid;
  logic [7:0] s_byte;
  logic       s_last;

  // per-packet state
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [1:0]  type_reg, type_reg_next;
  logic        trunc_reg, trunc_reg_next;
  logic [4:0]  window_reg, window_reg_next;
  logic [7:0]  seq_reg, seq_reg_next;
  logic [15:0] length_reg, length_reg_next;
  logic [31:0] stamp_reg, stamp_reg_next;
  logic [31:0] running_crc, running_crc_next;
  logic [31:0] received_crc, received_crc_next;
  logic [31:0] header_crc_reg, header_crc_reg_next;
  logic [2:0]  error_latch, error_latch_next;

  logic [POS_W-1:0] p;
  logic [POS_W-1:0] pay_end;
  logic [POS_W-1:0] pay_end4;
  logic [POS_W:0]   count;
  logic             expect_pay;
  logic             full;
  logic [7:0]       crc_in;
  logic [31:0]      crc_upd;
  logic [15:0]      len_shift;
  logic             emit_pay;
  logic [2:0]       st;
  result_t          pay_res;
  result_t          st_res;

  assign stage_busy = s_valid;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else begin
      s_valid <= in_take;
    end
    if (in_take) begin
      s_byte <= data_byte;
      s_last <= last_byte;
    end
  end

  assign p          = byte_position;
  assign expect_pay = !trunc_reg && (length_reg != 16'd0);
  assign pay_end    = POS_W'(HDR_BYTES) + {1'b0, length_reg};
  assign pay_end4   = pay_end + POS_W'(4);
  assign count      = {1'b0, p} + (POS_W+1)'(1);
  assign crc_in     = (p == '0) ? (s_byte & 8'hDF) : s_byte;
  assign crc_upd    = crc_byte(running_crc, crc_in);
  assign len_shift  = {length_reg[7:0], s_byte};

  // field decode, header checks and payload crc
  always_comb begin
    type_reg_next       = type_reg;
    trunc_reg_next      = trunc_reg;
    window_reg_next     = window_reg;
    seq_reg_next        = seq_reg;
    length_reg_next     = length_reg;
    stamp_reg_next      = stamp_reg;
    running_crc_next    = running_crc;
    received_crc_next   = received_crc;
    header_crc_reg_next = header_crc_reg;
    error_latch_next    = error_latch;
    emit_pay            = 1'b0;

    if (p == '0) begin
      type_reg_next    = s_byte[7:6];
      trunc_reg_next   = s_byte[5];
      window_reg_next  = s_byte[4:0];
      running_crc_next = crc_upd;
      if (!cfg.type_mask[s_byte[7:6]]) begin
        if (error_latch == ST_OK) error_latch_next = ST_BAD_TYPE;
      end else if (s_byte[4:0] == 5'd0 || s_byte[4:0] > cfg.max_window) begin
        if (error_latch == ST_OK) error_latch_next = ST_BAD_WINDOW;
      end
    end else if (p == POS_W'(1)) begin
      seq_reg_next     = s_byte;
      running_crc_next = crc_upd;
    end else if (p < POS_W'(4)) begin
      length_reg_next  = len_shift;
      running_crc_next = crc_upd;
      if (p == POS_W'(3) && {1'b0, len_shift} > 17'(MAX_PAYLOAD)) begin
        if (error_latch == ST_OK) error_latch_next = ST_BAD_LENGTH;
      end
    end else if (p < POS_W'(8)) begin
      stamp_reg_next[{p[1:0], 3'b000} +: 8] = s_byte;
      running_crc_next = crc_upd;
      if (p == POS_W'(7)) begin
        header_crc_reg_next = ~crc_upd;
        running_crc_next    = CRC_PRESET;
      end
    end else if (p < POS_W'(HDR_BYTES)) begin
      received_crc_next = {received_crc[23:0], s_byte};
      if (p == POS_W'(11)) begin
        if ({received_crc[23:0], s_byte} != header_crc_reg && error_latch == ST_OK) begin
          error_latch_next = ST_CRC_ERROR;
        end
        received_crc_next = 32'b0;
      end
    end else if (expect_pay) begin
      if (p < pay_end) begin
        running_crc_next = crc_upd;
        emit_pay         = (error_latch == ST_OK);
      end else if (p < pay_end4) begin
        received_crc_next = {received_crc[23:0], s_byte};
      end
    end
  end

  // final status from the updated state
  assign full = expect_pay && (count >= {1'b0, pay_end4});

  always_comb begin
    if (p < POS_W'(HDR_BYTES - 1)) begin
      st = ST_NO_HEADER;
    end else if (error_latch_next != ST_OK) begin
      st = error_latch_next;
    end else if (expect_pay && !full) begin
      st = ST_INCONSISTENT;
    end else if (expect_pay && received_crc_next != ~running_crc_next) begin
      st = ST_CRC_ERROR;
    end else begin
      st = ST_OK;
    end
  end

  always_comb begin
    pay_res              = '0;
    pay_res.kind         = KIND_PAYLOAD;
    pay_res.payload_byte = s_byte;

    st_res                = '0;
    st_res.kind           = KIND_STATUS;
    st_res.status         = st;
    st_res.pkt_type       = type_reg_next;
    st_res.truncated      = trunc_reg_next;
    st_res.window         = window_reg_next;
    st_res.seqnum         = seq_reg_next;
    st_res.payload_length = length_reg_next;
    st_res.timestamp      = stamp_reg_next;
    st_res.header_crc     = header_crc_reg_next;
    st_res.payload_crc    = full ? received_crc_next : 32'b0;
  end

  // results handed to the queue, payload before status
  always_comb begin
    wr_count = 2'd0;
    wr0      = st_res;
    wr1      = st_res;
    if (s_valid) begin
      if (emit_pay) begin
        wr0      = pay_res;
        wr_count = s_last ? 2'd2 : 2'd1;
      end else begin
        wr_count = s_last ? 2'd1 : 2'd0;
      end
    end
  end

  // state update; the status item returns everything to reset values
  always_ff @(posedge clk) begin
    if (rst || (s_valid && s_last)) begin
      byte_position  <= '0;
      type_reg       <= '0;
      trunc_reg      <= 1'b0;
      window_reg     <= '0;
      seq_reg        <= '0;
      length_reg     <= '0;
      stamp_reg      <= '0;
      running_crc    <= CRC_PRESET;
      received_crc   <= '0;
      header_crc_reg <= '0;
      error_latch    <= ST_OK;
    end else if (s_valid) begin
      byte_position  <= byte_position_next;
      type_reg       <= type_reg_next;
      trunc_reg      <= trunc_reg_next;
      window_reg     <= window_reg_next;
      seq_reg        <= seq_reg_next;
      length_reg     <= length_reg_next;
      stamp_reg      <= stamp_reg_next;
      running_crc    <= running_crc_next;
      received_crc   <= received_crc_next;
      header_crc_reg <= header_crc_reg_next;
      error_latch    <= error_latch_next;
    end
  end

  // saturating byte counter
  assign byte_position_next = (p == POS_MAX) ? p : p + POS_W'(1);

endmodule

>>> rtl/crcdfr_out_queue.sv
// result queue taking up to two results per cycle and giving one per transaction
// depends on crcdfr_pkg
module crcdfr_out_queue
  import crcdfr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          wr_count,
  input  result_t             wr0,
  input  result_t             wr1,
  output logic [QUEUE_AW:0]   fill,
  output logic                out_valid,
  input  logic                out_ready,
  output result_t             rd
);

  result_t              mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wptr;
  logic [QUEUE_AW-1:0]  rptr;
  logic [QUEUE_AW:0]    fill_next;
  logic                 pop;

  assign out_valid = (fill != '0);
  assign pop       = out_valid && out_ready;
  assign rd        = mem[rptr];
  assign fill_next = fill + (QUEUE_AW+1)'(wr_count) - (QUEUE_AW+1)'(pop);

  // storage writes
  always_ff @(posedge clk) begin
    if (wr_count != 2'd0) begin
      mem[wptr] <= wr0;
    end
    if (wr_count == 2'd2) begin
      mem[wptr + QUEUE_AW'(1)] <= wr1;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      wptr <= wptr + QUEUE_AW'(wr_count);
      if (pop) rptr <= rptr + QUEUE_AW'(1);
      fill <= fill_next;
    end
  end

endmodule

>>> rtl/crc_checked_packet_deframer_core.sv
// packet deframer with crc32 header/payload checks, one byte per cycle unless stalled
// an accepted byte is held in the input stage register, then its results enter the queue
// throughput: one byte per cycle; a final payload byte yields two results, drained one
// per cycle while out_ready is high through an eight-entry result queue; in_ready
// drops only when that queue lacks room for two results per byte in flight
// reset (rst, synchronous) clears parser state and queue, registers take their defaults
module crc_checked_packet_deframer_core
  import crcdfr_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [7:0]  payload_byte,
  output logic [2:0]  status,
  output logic [1:0]  pkt_type,
  output logic        truncated,
  output logic [4:0]  window,
  output logic [7:0]  seqnum,
  output logic [15:0] payload_length,
  output logic [31:0] timestamp,
  output logic [31:0] header_crc,
  output logic [31:0] payload_crc
);

  cfg_t              cfg;
  logic              stage_busy;
  logic [1:0]        wr_count;
  result_t           wr0;
  result_t           wr1;
  result_t           rd;
  logic [QUEUE_AW:0] fill;
  logic [QUEUE_AW+1:0] reserved;

  crcdfr_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // room for the byte in the stage and the new one, two results each
  assign reserved = (QUEUE_AW+2)'(fill) + (stage_busy ? (QUEUE_AW+2)'(2) : '0);
  assign in_ready = reserved <= (QUEUE_AW+2)'(QUEUE_DEPTH - 2);

  crcdfr_parse #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parse (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_take    (in_valid && in_ready),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .stage_busy (stage_busy),
    .wr_count   (wr_count),
    .wr0        (wr0),
    .wr1        (wr1)
  );

  crcdfr_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_count  (wr_count),
    .wr0       (wr0),
    .wr1       (wr1),
    .fill      (fill),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .rd        (rd)
  );

  // result fields
  assign kind           = rd.kind;
  assign payload_byte   = rd.payload_byte;
  assign status         = rd.status;
  assign pkt_type       = rd.pkt_type;
  assign truncated      = rd.truncated;
  assign window         = rd.window;
  assign seqnum         = rd.seqnum;
  assign payload_length = rd.payload_length;
  assign timestamp      = rd.timestamp;
  assign header_crc     = rd.header_crc;
  assign payload_crc    = rd.payload_crc;

endmodule
